>>> rtl/core/cascaded_pid_motor_current_assert.svh
// Assertion macros for the cascaded PID current controller
`ifndef CASCADED_PID_MOTOR_CURRENT_ASSERT_SVH
`define CASCADED_PID_MOTOR_CURRENT_ASSERT_SVH
// implication checked on every edge out of reset
`define CPMC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// implication with the consequent in the following cycle
`define CPMC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

>>> rtl/core/cpmc_pkg.sv
// Shared types and constants for the cascaded PID current controller
package cpmc_pkg;
    localparam logic [1:0] OP_POSITION = 2'd0;
    localparam logic [1:0] OP_SPEED    = 2'd1;
    localparam logic [1:0] OP_DIRECT   = 2'd2;
    localparam logic [1:0] OP_UNUSED   = 2'd3;

    localparam logic [2:0] REG_SPEED_KP     = 3'd0;
    localparam logic [2:0] REG_SPEED_KI     = 3'd1;
    localparam logic [2:0] REG_SPEED_KD     = 3'd2;
    localparam logic [2:0] REG_POSITION_KP  = 3'd3;
    localparam logic [2:0] REG_POSITION_KI  = 3'd4;
    localparam logic [2:0] REG_POSITION_KD  = 3'd5;
    localparam logic [2:0] REG_SPEED_SEP    = 3'd6;
    localparam logic [2:0] REG_POSITION_SEP = 3'd7;

    localparam int CFG_DATA_W = 31;
    localparam int GAIN_W     = 16;
    // multiplicand width for the serial multiplier and the accumulator
    localparam int MAC_W  = 42;
    localparam int ACC_W  = 60;
endpackage

>>> rtl/core/cpmc_mac.sv
// Bit-serial multiply-accumulate: one gain bit per cycle
module cpmc_mac
    import cpmc_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    input  logic                     i_clear,
    input  logic signed [MAC_W-1:0]  i_a,
    input  logic [GAIN_W-1:0]        i_gain,
    output logic                     o_done,
    output logic signed [ACC_W-1:0]  o_acc
);
    logic signed [ACC_W-1:0] r_acc, n_acc;
    logic signed [ACC_W-1:0] r_a;
    logic [GAIN_W-1:0]       r_g;
    logic [4:0]              r_cnt;
    logic                    r_busy, r_done;

    always_comb begin
        n_acc = r_acc;
        if (r_g[0]) n_acc = r_acc + r_a;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
            r_acc  <= '0;
        end else begin
            r_done <= !i_start && r_busy && (r_cnt == 5'd1);
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 5'(GAIN_W);
                r_a    <= ACC_W'(i_a);
                r_g    <= i_gain;
                if (i_clear) r_acc <= '0;
            end else if (r_busy) begin
                r_acc <= n_acc;
                r_a   <= r_a <<< 1;
                r_g   <= r_g >> 1;
                r_cnt <= r_cnt - 5'd1;
                if (r_cnt == 5'd1) r_busy <= 1'b0;
            end
        end
    end

    assign o_done = r_done;
    assign o_acc  = r_acc;
endmodule

>>> rtl/core/cascaded_pid_motor_current.sv
// Top level of the cascaded position/speed PID current controller.
// From input transfer to o_valid, direct mode and dropped items go straight to the output; the
// speed loop runs a serial decay divide, then three 16-bit serial products, and the position
// cascade runs six products with the divide hidden behind them.
// One item in flight; the next input is accepted only once the result has been taken.
// Reset (synchronous, active low) clears gains, integrators and last errors.
`include "cascaded_pid_motor_current_assert.svh"
module cascaded_pid_motor_current
    import cpmc_pkg::*;
#(
    parameter int MOTORS = 8,
    parameter int CURRENT_LIMIT_RAW = 10000,
    parameter int SPEED_INTEGRAL_LIMIT = 1048576,
    parameter int POSITION_INTEGRAL_LIMIT = 1048576
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [2:0]            i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [1:0]            i_op,
    input  logic [2:0]            i_motor_index,
    input  logic signed [31:0]    i_target_position,
    input  logic signed [31:0]    i_feedback_position,
    input  logic signed [23:0]    i_target_speed,
    input  logic signed [23:0]    i_feedback_speed,
    input  logic signed [15:0]    i_target_current,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [2:0]            o_motor_index_res,
    output logic signed [14:0]    o_current_command
);
    localparam int MI_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;
    localparam logic signed [ACC_W-1:0] CLIM = ACC_W'(CURRENT_LIMIT_RAW);
    localparam logic signed [41:0] PLIM = 42'(POSITION_INTEGRAL_LIMIT);
    localparam logic signed [41:0] SLIM = 42'(SPEED_INTEGRAL_LIMIT);

    // configuration registers
    logic [15:0] r_skp, r_ski, r_skd, r_pkp, r_pki, r_pkd;
    logic [22:0] r_ssep;
    logic [30:0] r_psep;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_skp <= '0; r_ski <= '0; r_skd <= '0;
            r_pkp <= '0; r_pki <= '0; r_pkd <= '0;
            r_ssep <= 23'h7FFFFF;
            r_psep <= 31'h7FFFFFFF;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_SPEED_KP:     r_skp  <= i_cfg_data[15:0];
                REG_SPEED_KI:     r_ski  <= i_cfg_data[15:0];
                REG_SPEED_KD:     r_skd  <= i_cfg_data[15:0];
                REG_POSITION_KP:  r_pkp  <= i_cfg_data[15:0];
                REG_POSITION_KI:  r_pki  <= i_cfg_data[15:0];
                REG_POSITION_KD:  r_pkd  <= i_cfg_data[15:0];
                REG_SPEED_SEP:    r_ssep <= i_cfg_data[22:0];
                REG_POSITION_SEP: r_psep <= i_cfg_data[30:0];
                default: ;
            endcase
        end
    end

    // per-motor loop state, flip-flops indexed by motor
    logic signed [31:0] r_sint [MOTORS];
    logic signed [39:0] r_pint [MOTORS];
    logic signed [24:0] r_lse  [MOTORS];
    logic signed [32:0] r_lpe  [MOTORS];

    typedef enum logic [3:0] {
        S_IDLE, S_PERR, S_PMUL, S_PFIN, S_SERR, S_SMUL, S_SFIN, S_OUT
    } t_state;

    t_state r_state;
    logic [2:0]  r_mi;
    logic [MI_W-1:0] r_m;
    logic signed [23:0] r_fs;
    logic signed [32:0] r_ep;
    logic signed [24:0] r_es;
    logic signed [23:0] r_st;
    logic signed [39:0] r_pi_new;
    logic signed [31:0] r_si_new;
    logic [1:0]  r_term;
    logic        r_ovalid;
    logic signed [14:0] r_cur;
    logic        r_pend;

    // serial divide by 5 for the speed integrator decay
    logic [32:0] r_dq;
    logic [2:0]  r_drem;
    logic [5:0]  r_dcnt;
    logic        r_dneg;
    logic        w_dstart;
    logic [3:0]  w_dtry;
    logic signed [31:0] w_sint_in;
    logic [32:0] w_sint_mag;

    // multiplier operand and gain selection
    logic signed [MAC_W-1:0] w_a;
    logic [GAIN_W-1:0]       w_g;
    logic                    w_start, w_clear, w_done;
    logic signed [ACC_W-1:0] w_acc;
    logic                    w_pos;

    assign w_pos = (r_state == S_PMUL);

    always_comb begin
        logic signed [41:0] cl;
        if (w_pos) cl = (42'(r_pi_new) > PLIM) ? PLIM :
                        (42'(r_pi_new) < -PLIM) ? -PLIM : 42'(r_pi_new);
        else       cl = (42'(r_si_new) > SLIM) ? SLIM :
                        (42'(r_si_new) < -SLIM) ? -SLIM : 42'(r_si_new);
        unique case (r_term)
            2'd0: begin
                w_a = w_pos ? 42'(r_ep) : 42'(r_es);
                w_g = w_pos ? r_pkp : r_skp;
            end
            2'd1: begin
                w_a = cl;
                w_g = w_pos ? r_pki : r_ski;
            end
            default: begin
                w_a = w_pos ? 42'(r_ep) - 42'(r_lpe[r_m]) : 42'(r_es) - 42'(r_lse[r_m]);
                w_g = w_pos ? r_pkd : r_skd;
            end
        endcase
    end

    assign w_start = (r_state == S_PMUL || r_state == S_SMUL) && r_pend;
    assign w_clear = (r_term == 2'd0);

    cpmc_mac u_mac (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_start(w_start),
        .i_clear(w_clear),
        .i_a    (w_a),
        .i_gain (w_g),
        .o_done (w_done),
        .o_acc  (w_acc)
    );

    logic signed [ACC_W-1:0] w_fl;
    assign w_fl = w_acc >>> 8;

    logic signed [25:0] w_es_abs;
    logic signed [33:0] w_ep_abs;
    logic signed [40:0] w_pi_abs;
    logic signed [32:0] w_sint_sum;
    logic signed [31:0] w_dec;

    assign w_ep_abs = r_ep[32] ? -34'(r_ep) : 34'(r_ep);
    assign w_es_abs = r_es[24] ? -26'(r_es) : 26'(r_es);
    assign w_pi_abs = r_pint[r_m][39] ? -41'(r_pint[r_m]) : 41'(r_pint[r_m]);
    assign w_sint_sum = 33'(r_sint[r_m]) + 33'(r_es);

    // 0.4 decay: |2x|/5 one quotient bit per cycle, sign put back after (toward zero).
    // Started at the input transfer; the speed integral does not move before it is used.
    assign w_dstart = (r_state == S_IDLE) && i_valid && !r_ovalid &&
                      (32'(i_motor_index) < MOTORS);
    assign w_sint_in = r_sint[MI_W'(i_motor_index)];
    assign w_sint_mag = w_sint_in[31] ? -33'(w_sint_in) : 33'(w_sint_in);
    assign w_dtry = {r_drem, r_dq[32]};
    assign w_dec = r_dneg ? -32'(r_dq) : 32'(r_dq);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dq   <= '0;
            r_drem <= '0;
            r_dcnt <= '0;
            r_dneg <= 1'b0;
        end else if (w_dstart) begin
            r_dq   <= {w_sint_mag[31:0], 1'b0};
            r_drem <= '0;
            r_dcnt <= 6'd33;
            r_dneg <= w_sint_in[31];
        end else if (r_dcnt != 6'd0) begin
            r_dcnt <= r_dcnt - 6'd1;
            if (w_dtry >= 4'd5) begin
                r_drem <= 3'(w_dtry - 4'd5);
                r_dq   <= {r_dq[31:0], 1'b1};
            end else begin
                r_drem <= w_dtry[2:0];
                r_dq   <= {r_dq[31:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_pend   <= 1'b0;
            r_term   <= '0;
            for (int k = 0; k < MOTORS; k++) begin
                r_sint[k] <= '0; r_pint[k] <= '0; r_lse[k] <= '0; r_lpe[k] <= '0;
            end
        end else begin
            if (r_ovalid && i_ready) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: if (i_valid && !r_ovalid) begin
                    r_mi <= i_motor_index;
                    r_m  <= MI_W'(i_motor_index);
                    r_fs <= i_feedback_speed;
                    r_ep <= 33'(i_target_position) - 33'(i_feedback_position);
                    r_st <= i_target_speed;
                    if (32'(i_motor_index) >= MOTORS || i_op == OP_UNUSED) begin
                        r_cur <= '0;
                        r_state <= S_OUT;
                    end else if (i_op == OP_DIRECT) begin
                        r_cur <= (32'(i_target_current) > CURRENT_LIMIT_RAW) ?
                                 15'(CURRENT_LIMIT_RAW) :
                                 (32'(i_target_current) < -CURRENT_LIMIT_RAW) ?
                                 -15'(CURRENT_LIMIT_RAW) : 15'(i_target_current);
                        r_state <= S_OUT;
                    end else if (i_op == OP_POSITION) begin
                        r_state <= S_PERR;
                    end else begin
                        r_state <= S_SERR;
                    end
                end
                S_PERR: begin
                    if (w_ep_abs >= 34'(r_psep)) r_pi_new <= '0;
                    else if (w_pi_abs <= 41'(POSITION_INTEGRAL_LIMIT))
                        r_pi_new <= r_pint[r_m] + 40'(r_ep);
                    else r_pi_new <= r_pint[r_m];
                    r_term <= 2'd0;
                    r_pend <= 1'b1;
                    r_state <= S_PMUL;
                end
                S_PMUL, S_SMUL: begin
                    if (w_done && r_term == 2'd2) begin
                        r_pend <= 1'b0;
                        r_state <= (r_state == S_PMUL) ? S_PFIN : S_SFIN;
                    end else if (w_done) begin
                        r_term <= r_term + 2'd1;
                        r_pend <= 1'b1;
                    end else begin
                        r_pend <= 1'b0;
                    end
                end
                S_PFIN: begin
                    r_pint[r_m] <= r_pi_new;
                    r_lpe[r_m]  <= r_ep;
                    r_st <= (w_fl > 60'sd8388607) ? 24'sh7FFFFF :
                            (w_fl < -60'sd8388608) ? 24'sh800000 : 24'(w_fl);
                    r_state <= S_SERR;
                end
                // waits for the decay quotient before the speed products start
                S_SERR: if (r_dcnt == 6'd0) begin
                    r_es <= 25'(r_st) - 25'(r_fs);
                    r_state <= S_SMUL;
                    r_term <= 2'd0;
                    r_pend <= 1'b1;
                end
                S_SFIN: begin
                    r_sint[r_m] <= r_si_new;
                    r_lse[r_m]  <= r_es;
                    r_cur <= (w_fl > CLIM) ? 15'(CURRENT_LIMIT_RAW) :
                             (w_fl < -CLIM) ? -15'(CURRENT_LIMIT_RAW) : 15'(w_fl);
                    r_state <= S_OUT;
                end
                S_OUT: if (!r_ovalid) begin
                    r_ovalid <= 1'b1;
                    o_motor_index_res <= r_mi;
                    o_current_command <= r_cur;
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
            // speed integral update computed once the error is registered
            if (r_state == S_SMUL && r_pend && r_term == 2'd0) begin
                if (w_es_abs >= 26'(r_ssep)) r_si_new <= w_dec;
                else if (w_sint_sum > 33'sh07FFFFFFF) r_si_new <= 32'sh7FFFFFFF;
                else if (w_sint_sum < -33'sh080000000) r_si_new <= 32'sh80000000;
                else r_si_new <= 32'(w_sint_sum);
            end
        end
    end

    assign o_ready = (r_state == S_IDLE) && !r_ovalid;
    assign o_valid = r_ovalid;

    `CPMC_ASSERT_IMP(a_ready_idle, i_clk, i_rst_n, o_ready, r_state == S_IDLE)
    `CPMC_ASSERT_NEXT(a_take_busy, i_clk, i_rst_n, i_valid && o_ready, !o_ready)
    `CPMC_ASSERT_IMP(a_cur_lim, i_clk, i_rst_n, o_valid,
        o_current_command <= 15'(CURRENT_LIMIT_RAW) &&
        o_current_command >= -15'(CURRENT_LIMIT_RAW))
endmodule
